FILE: src/ims_pkg.sv
// Package of shared constants and types for the interleaved multi-stack core.
package ims_pkg;

  localparam int NUM_STACKS  = 3;
  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int SLOT_TOTAL  = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W      = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

  localparam int OP_W     = 2;
  localparam int SID_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

FILE: src/ims_if.sv
// Valid/ready channel interfaces for requests and results of the multi-stack core.
interface ims_req_if import ims_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [SID_W-1:0]   stack_sel;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output operation, output stack_sel, output value,
                  input ready);
  modport sink   (input valid, input operation, input stack_sel, input value,
                  output ready);
endinterface

interface ims_rsp_if import ims_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  top_value;
  logic [CNT_W-1:0]    stack_count;
  logic                is_empty;

  modport source (output valid, output status, output top_value, output stack_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input top_value, input stack_count,
                  input is_empty, output ready);
endinterface

FILE: src/interleaved_multi_stack_core.sv
// Top level of the interleaved multi-stack core: shared slot memory, counts, result stages.
// A request outcome is registered in stage one and then in the output register before
// the result is offered on the result side.
// Throughput: one request per cycle while results are taken; each request makes at most
// one slot memory access (a write for push, a read for peek), so a single port is enough.
// Reset (synchronous, active low) clears all stack counts and the valid flags of both result stages.
// The slot memory is not cleared; an entry is read only after a push has written it.
module interleaved_multi_stack_core import ims_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ims_req_if.sink   in_chan,
  ims_rsp_if.source out_chan
);

  // Slot memory: entry n of stack s sits at address s + n*NUM_STACKS.
  logic [DATA_WIDTH-1:0] slot_mem [SLOT_TOTAL];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Per-stack entry counts live in flops so the next request sees the update at once.
  logic [CNT_W-1:0] counts_r [NUM_STACKS];

  // Stage one holds the request outcome while the memory read completes.
  logic                s1_valid_r;
  logic [STATUS_W-1:0] s1_status_r;
  logic [CNT_W-1:0]    s1_count_r;
  logic                s1_peek_ok_r;

  // Output register decouples the result side from the request side.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_top_r;
  logic [CNT_W-1:0]    out_count_r;

  logic                in_xfer;
  logic                s1_move;
  logic                sid_ok;
  logic [CNT_W-1:0]    cnt_cur;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [CNT_W-1:0]    slot_idx;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_wr_en;
  logic                mem_rd_en;
  logic [STATUS_W-1:0] status_nxt;
  logic                peek_ok_nxt;

  // Stage one advances when the output register is free or its result is taken.
  // A new request enters whenever stage one is empty or advancing.
  assign s1_move      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_move;
  assign in_xfer      = in_chan.valid && in_chan.ready;

  assign sid_ok  = (32'(in_chan.stack_sel) < NUM_STACKS);
  assign cnt_cur = sid_ok ? counts_r[in_chan.stack_sel] : '0;

  // Decode the request: new count, status, and the one memory access it needs.
  always_comb begin
    cnt_nxt     = cnt_cur;
    status_nxt  = ST_OK;
    peek_ok_nxt = 1'b0;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    slot_idx    = cnt_cur;
    if (sid_ok) begin
      case (in_chan.operation)
        OP_PUSH: begin
          if (32'(cnt_cur) >= STACK_DEPTH) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            cnt_nxt   = cnt_cur + CNT_W'(1);
            mem_wr_en = in_xfer;
          end
        end
        OP_POP: begin
          if (cnt_cur == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            cnt_nxt = cnt_cur - CNT_W'(1);
          end
        end
        OP_PEEK: begin
          if (cnt_cur == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            slot_idx    = cnt_cur - CNT_W'(1);
            peek_ok_nxt = 1'b1;
            mem_rd_en   = in_xfer;
          end
        end
        default: begin
          // The unused operation code changes nothing and reports status ok.
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // Interleaved address: a small constant multiply, computed combinationally.
  assign mem_addr = ADDR_W'(in_chan.stack_sel) + ADDR_W'(slot_idx) * ADDR_W'(NUM_STACKS);

  // Single-port synchronous memory with registered read data. The read data only
  // changes on a peek transfer, so it holds while stage one waits on the output.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      slot_mem[mem_addr] <= in_chan.value[DATA_WIDTH-1:0];
    end
    if (mem_rd_en) begin
      rd_data_r <= slot_mem[mem_addr];
    end
  end

  // Count update on every transfer to an existing stack.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        counts_r[i] <= '0;
      end
    end else if (in_xfer && sid_ok) begin
      counts_r[in_chan.stack_sel] <= cnt_nxt;
    end
  end

  // Stage one control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_status_r  <= status_nxt;
      s1_count_r   <= cnt_nxt;
      s1_peek_ok_r <= peek_ok_nxt;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Output register payload; only a successful peek carries the memory word.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status_r <= s1_status_r;
      out_count_r  <= s1_count_r;
      out_top_r    <= s1_peek_ok_r ? VALUE_W'(rd_data_r) : '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.top_value   = out_top_r;
  assign out_chan.stack_count = out_count_r;
  assign out_chan.is_empty    = (out_count_r == '0);

  // An overflow result always reports a full stack.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OVERFLOW) |-> (32'(out_count_r) == STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  // An underflow result always reports an empty stack.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_UNDERFLOW) |-> (out_count_r == '0))
    else $error("underflow reported on a stack that is not empty");

  // Only an ok result can carry a nonzero top value.
  a_top_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_top_r != '0) |-> (out_status_r == ST_OK))
    else $error("nonzero top value on a failed request");

  // Peek data waiting in stage one must not be disturbed while it is stalled.
  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_peek_ok_r && !s1_move) |=> $stable(rd_data_r))
    else $error("memory read data changed under a stalled result");

  // A push on a non-full stack grows its count by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && sid_ok && in_chan.operation == OP_PUSH && status_nxt == ST_OK)
      |=> (s1_count_r == $past(cnt_cur) + CNT_W'(1)))
    else $error("push did not advance the stack count");

endmodule

FILE: verif/interleaved_multi_stack_core_tb.sv
// Self-checking testbench for the interleaved multi-stack core: directed table, then random traffic.
`timescale 1ns / 1ps

module interleaved_multi_stack_core_tb;
  import ims_pkg::*;

  // Operation code 3 is not a real operation. The core must leave every stack
  // alone and still answer with the addressed stack's count.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  // The first stack index past the last real stack. Requests to it are ignored.
  localparam logic [SID_W-1:0] SID_BAD = SID_W'(NUM_STACKS);

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned HOLD_AFTER    = 150;  // requests sent before the long hold
  localparam int unsigned PAUSE_AT      = 350;  // request index of the full drain
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned CALM_ITEMS    = 100;  // last random requests with no idling
  localparam int unsigned CHUNK_ITEMS   = 60;
  localparam int unsigned DRAIN_CYCLES  = 8;    // idle clocks after the last answer is checked

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [SID_W-1:0]   stack_sel;
    logic [VALUE_W-1:0] value;
  } stack_req_t;

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  top_value;
    logic [CNT_W-1:0]    stack_count;
    logic                is_empty;
  } stack_rsp_t;

  // One row of the directed table. A row may repeat its request; the pushed
  // value then steps up by one per repeat. Rows with a typed answer carry it
  // here; all other rows are checked against the stack model below.
  typedef struct {
    int unsigned reps;
    stack_req_t  req;
    bit          typed;
    stack_rsp_t  answer;
  } script_row_t;

  logic clk;
  logic rst_n;

  ims_req_if stack_req ();
  ims_rsp_if stack_rsp ();

  interleaved_multi_stack_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (stack_req),
    .out_chan(stack_rsp)
  );

  // Model state: the shared slot memory and the per-stack entry counts.
  logic [DATA_WIDTH-1:0] slot_word [SLOT_TOTAL];
  int unsigned           entry_count [NUM_STACKS];

  // Answers still owed by the core, oldest first.
  stack_rsp_t  owed_answers[$];
  script_row_t script_rows[$];

  int unsigned requests_sent;
  int unsigned answers_checked;
  int unsigned overflow_seen;
  int unsigned underflow_seen;
  int unsigned failures;
  bit          long_hold_done;
  bit          calm_tail;

  // The clock runs free from time zero.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the stack model and return the answer it must cause.
  // Only entries below a stack's count are read, so the model never reads a
  // slot that no push has written.
  function automatic stack_rsp_t model_stack_op(stack_req_t r);
    stack_rsp_t  ans;
    int unsigned depth_now;
    ans = '{status: ST_OK, top_value: '0, stack_count: '0, is_empty: 1'b1};
    if (r.stack_sel >= NUM_STACKS) return ans;
    depth_now = entry_count[r.stack_sel];
    case (r.operation)
      OP_PUSH: begin
        if (depth_now >= STACK_DEPTH) begin
          ans.status = ST_OVERFLOW;
        end else begin
          slot_word[r.stack_sel + depth_now * NUM_STACKS] = r.value[DATA_WIDTH-1:0];
          depth_now++;
        end
      end
      OP_POP: begin
        if (depth_now == 0) ans.status = ST_UNDERFLOW;
        else depth_now--;
      end
      OP_PEEK: begin
        if (depth_now == 0) begin
          ans.status = ST_UNDERFLOW;
        end else begin
          ans.top_value = VALUE_W'(slot_word[r.stack_sel + (depth_now - 1) * NUM_STACKS]);
        end
      end
      default: ;
    endcase
    entry_count[r.stack_sel] = depth_now;
    ans.stack_count = CNT_W'(depth_now);
    ans.is_empty    = (depth_now == 0);
    return ans;
  endfunction

  task automatic add_row(int unsigned reps, logic [OP_W-1:0] op, logic [SID_W-1:0] sid,
                         logic [VALUE_W-1:0] value, bit typed, stack_rsp_t answer);
    script_row_t row;
    row.reps   = reps;
    row.req    = '{operation: op, stack_sel: sid, value: value};
    row.typed  = typed;
    row.answer = answer;
    script_rows.push_back(row);
  endtask

  // Offer one request and hold it until the core takes it. A random idle burst
  // may come first, except in the calm tail of the run. Valid stays high after
  // the transfer so that back-to-back requests need no gap.
  task automatic issue_request(stack_req_t r, bit typed, stack_rsp_t answer);
    stack_rsp_t predicted;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      stack_req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    stack_req.valid     <= 1'b1;
    stack_req.operation <= r.operation;
    stack_req.stack_sel <= r.stack_sel;
    stack_req.value     <= r.value;
    @(posedge clk);
    while (!stack_req.ready) @(posedge clk);
    // The transfer happened at this edge; the model moves with it.
    predicted = model_stack_op(r);
    owed_answers.push_back(typed ? answer : predicted);
    requests_sent++;
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      failures++;
    end
  endtask

  // Result checker. Every result transfer is matched against the oldest owed
  // answer, field by field; a result with nothing owed is a failure too.
  always @(posedge clk) begin
    stack_rsp_t want;
    if (rst_n && stack_rsp.valid && stack_rsp.ready) begin
      if (owed_answers.size() == 0) begin
        $display("%0t: result with no request outstanding, status %0d top 0x%0h count %0d",
                 $time, stack_rsp.status, stack_rsp.top_value, stack_rsp.stack_count);
        failures++;
      end else begin
        want = owed_answers.pop_front();
        check_field("status", want.status, stack_rsp.status);
        check_field("top_value", want.top_value, stack_rsp.top_value);
        check_field("stack_count", want.stack_count, stack_rsp.stack_count);
        check_field("is_empty", want.is_empty, stack_rsp.is_empty);
        answers_checked++;
        if (stack_rsp.status == ST_OVERFLOW) overflow_seen++;
        if (stack_rsp.status == ST_UNDERFLOW) underflow_seen++;
      end
    end
  end

  // Result receiver. It alternates stretches of readiness with idle bursts,
  // holds off once for a long stretch so that the core backs up and stalls its
  // input, and stays ready for the whole calm tail.
  initial begin
    int unsigned span;
    stack_rsp.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm_tail) begin
        stack_rsp.ready <= 1'b1;
        @(posedge clk);
      end else if (!long_hold_done && requests_sent >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stack_rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(1, 40);
        stack_rsp.ready <= 1'b1;
        repeat (span) @(posedge clk);
        span = $urandom_range(1, 19);
        stack_rsp.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: watchdog expired with %0d answers still owed", $time, owed_answers.size());
    $display("[interleaved_multi_stack_core] ERROR");
    $finish;
  end

  // Stimulus: reset, the directed table, then random traffic in chunks.
  initial begin
    stack_req_t  r;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned pick;
    int unsigned focus;
    bit          push_heavy;

    rst_n                <= 1'b0;
    stack_req.valid      <= 1'b0;
    stack_req.operation  <= '0;
    stack_req.stack_sel  <= '0;
    stack_req.value      <= '0;
    requests_sent   = 0;
    answers_checked = 0;
    overflow_seen   = 0;
    underflow_seen  = 0;
    failures        = 0;
    long_hold_done  = 1'b0;
    calm_tail       = 1'b0;
    foreach (entry_count[i]) entry_count[i] = 0;
    foreach (slot_word[i]) slot_word[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty stacks after reset answer pop and peek with underflow.
    add_row(1, OP_POP,  2'd0, 32'h0, 1, '{ST_UNDERFLOW, 32'h0, 5'd0, 1'b1});
    add_row(1, OP_PEEK, 2'd2, 32'h0, 1, '{ST_UNDERFLOW, 32'h0, 5'd0, 1'b1});
    // Both value extremes go in and come back out through peek.
    add_row(1, OP_PUSH, 2'd0, 32'h0000_0000, 1, '{ST_OK, 32'h0, 5'd1, 1'b0});
    add_row(1, OP_PUSH, 2'd0, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0, 5'd2, 1'b0});
    add_row(1, OP_PEEK, 2'd0, 32'h0, 1, '{ST_OK, 32'hFFFF_FFFF, 5'd2, 1'b0});
    add_row(1, OP_POP,  2'd0, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0, 5'd1, 1'b0});
    add_row(1, OP_PEEK, 2'd0, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0, 5'd1, 1'b0});
    // Neighbouring stacks share the memory in interleaved slots.
    add_row(1, OP_PUSH, 2'd1, 32'hA5A5_A5A5, 0, '0);
    add_row(1, OP_PUSH, 2'd2, 32'h5A5A_5A5A, 0, '0);
    add_row(1, OP_PEEK, 2'd1, 32'h0, 0, '0);
    // The unknown operation changes nothing but still reports the count.
    add_row(1, OP_UNKNOWN, 2'd1, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0, 5'd1, 1'b0});
    // A stack index past the last stack is ignored and reads as empty.
    add_row(1, OP_PUSH,    SID_BAD, 32'hFFFF_FFFF, 1, '{ST_OK, 32'h0, 5'd0, 1'b1});
    add_row(1, OP_PEEK,    SID_BAD, 32'h0, 1, '{ST_OK, 32'h0, 5'd0, 1'b1});
    add_row(1, OP_UNKNOWN, SID_BAD, 32'h0, 1, '{ST_OK, 32'h0, 5'd0, 1'b1});
    // Fill stack two to the top; one more push overflows and changes nothing.
    add_row(STACK_DEPTH - 1, OP_PUSH, 2'd2, 32'h1234_0000, 0, '0);
    add_row(1, OP_PUSH, 2'd2, 32'hDEAD_BEEF, 1,
            '{ST_OVERFLOW, 32'h0, CNT_W'(STACK_DEPTH), 1'b0});
    add_row(1, OP_PEEK, 2'd2, 32'h0, 0, '0);
    add_row(1, OP_POP,  2'd2, 32'h0, 0, '0);

    foreach (script_rows[i]) begin
      for (int unsigned k = 0; k < script_rows[i].reps; k++) begin
        r = script_rows[i].req;
        r.value = r.value + VALUE_W'(k);
        issue_request(r, script_rows[i].typed, script_rows[i].answer);
      end
    end

    // Random traffic. Each chunk leans toward pushes or pops and mostly works
    // on one stack, so stacks run all the way to full and back to empty.
    push_heavy = 1'b1;
    focus      = 0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % CHUNK_ITEMS == 0) begin
        push_heavy = ~push_heavy;
        focus      = $urandom_range(0, NUM_STACKS - 1);
        push_pct   = push_heavy ? 65 : 20;
        pop_pct    = push_heavy ? 18 : 55;
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;

      // Once, the sender stops until every owed answer has come back.
      if (requests_sent == PAUSE_AT) begin
        stack_req.valid <= 1'b0;
        @(posedge clk);
        while (owed_answers.size() != 0) @(posedge clk);
      end

      pick = $urandom_range(0, 99);
      if (pick < 4) r.operation = OP_UNKNOWN;
      else if (pick < 4 + push_pct) r.operation = OP_PUSH;
      else if (pick < 4 + push_pct + pop_pct) r.operation = OP_POP;
      else r.operation = OP_PEEK;

      pick = $urandom_range(0, 99);
      if (pick < 4) r.stack_sel = SID_BAD;
      else if (pick < 74) r.stack_sel = SID_W'(focus);
      else r.stack_sel = SID_W'($urandom_range(0, NUM_STACKS - 1));

      r.value = $urandom;
      issue_request(r, 1'b0, '0);
    end
    stack_req.valid <= 1'b0;

    while (owed_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests through %0d stacks; checked %0d results.",
             requests_sent, NUM_STACKS, answers_checked);
    $display("Saw %0d overflow and %0d underflow results; %0d field mismatches.",
             overflow_seen, underflow_seen, failures);
    if (failures == 0) begin
      $display("[interleaved_multi_stack_core] OK");
    end else begin
      $display("[interleaved_multi_stack_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ims_pkg.sv
src/ims_if.sv
src/interleaved_multi_stack_core.sv
verif/interleaved_multi_stack_core_tb.sv
